// ===== hdl/ita_pkg.sv =====
`default_nettype none

package ita_pkg;

  // Width of the integer word that is formatted.
  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int DEC_CELLS = VALUE_WIDTH * 302 / 1000 + 1;
  // Hex digits needed for the full unsigned word.
  localparam int HEX_CELLS = (VALUE_WIDTH + 3) / 4;
  localparam int NUM_CELLS = (DEC_CELLS > HEX_CELLS) ? DEC_CELLS : HEX_CELLS;
  localparam int PAD_WIDTH = NUM_CELLS * 4;

  localparam int CNT_W  = $clog2(NUM_CELLS + 1);
  localparam int IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int ITER_W = $clog2(VALUE_WIDTH);

  localparam int CHAR_WIDTH = 8;

  // ASCII codes.
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWA  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] HEX_LETTER_OFFSET = 8'd10;
  localparam logic [3:0] DEC_DIGIT_MAX = 4'd9;

  // Radix mode codes.
  localparam logic RADIX_DEC = 1'b0;
  localparam logic RADIX_HEX = 1'b1;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_t;

  // Finished conversion handed from the converter to the character emitter.
  typedef struct packed {
    logic                        neg;
    logic [CNT_W-1:0]            ndig;
    digit_t [NUM_CELLS-1:0]      digits;
  } ita_result_t;

  // Maps one digit value (0 to 15) to its lower-case ASCII code.
  function automatic logic [CHAR_WIDTH-1:0] digit_char(input digit_t d);
    logic [CHAR_WIDTH-1:0] wide;
    wide = CHAR_WIDTH'(d);
    if (d <= DEC_DIGIT_MAX) begin
      return CH_ZERO + wide;
    end
    return CH_LOWA + wide - HEX_LETTER_OFFSET;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ita_cell.sv =====
`default_nettype none

module ita_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  ita_pkg::digit_t load_digit,
  input  logic            carry_in,
  output logic            carry_out,
  output ita_pkg::digit_t digit
);
  import ita_pkg::*;

  digit_t adj;

  // Add three to a digit of five or more before it doubles, so that the
  // carry leaves at bit 3 exactly when the decimal digit overflows.
  assign adj       = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign carry_out = adj[3];

  // Each shift doubles the digit and takes in the neighbor's carry.
  always_ff @(posedge clk) begin
    if (load) begin
      digit <= load_digit;
    end else if (shift) begin
      digit <= {adj[2:0], carry_in};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ita_conv.sv =====
`default_nettype none

module ita_conv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ita_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                mode,
  output logic                                hand_valid,
  input  logic                                hand_ready,
  output ita_pkg::ita_result_t                result
);
  import ita_pkg::*;

  conv_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] word;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] mag_load;
  logic [ITER_W-1:0]      iter;
  logic                   neg;
  logic                   accept;
  logic                   shift_en;
  logic [PAD_WIDTH-1:0]   padded;
  logic [NUM_CELLS:0]     carry;
  digit_t [NUM_CELLS-1:0] digits;
  digit_t [NUM_CELLS-1:0] load_digits;
  logic [CNT_W-1:0]       ndig;

  assign word     = value;
  assign accept   = in_valid && in_ready;
  assign padded   = PAD_WIDTH'(word);
  // Decimal mode works on the magnitude; the most negative value comes out
  // as 2^(VALUE_WIDTH-1), which still fits the unsigned word.
  assign mag_load = (word[VALUE_WIDTH-1] && (mode == RADIX_DEC)) ? (~word + 1'b1) : word;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      CONV_IDLE: begin
        if (accept) begin
          state_next = (mode == RADIX_HEX) ? CONV_DONE : CONV_RUN;
        end
      end
      CONV_RUN: begin
        if (iter == '0) begin
          state_next = CONV_DONE;
        end
      end
      CONV_DONE: begin
        if (accept) begin
          state_next = (mode == RADIX_HEX) ? CONV_DONE : CONV_RUN;
        end else if (hand_ready) begin
          state_next = CONV_IDLE;
        end
      end
      default: begin
        state_next = CONV_IDLE;
      end
    endcase
  end

  // State outputs. A new word enters in the cycle its predecessor leaves.
  always_comb begin
    in_ready   = 1'b0;
    hand_valid = 1'b0;
    shift_en   = 1'b0;
    case (state)
      CONV_IDLE: begin
        in_ready = 1'b1;
      end
      CONV_RUN: begin
        shift_en = 1'b1;
      end
      CONV_DONE: begin
        hand_valid = 1'b1;
        in_ready   = hand_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Magnitude shift register feeding the digit chain, MSB first.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag  <= mag_load;
      iter <= ITER_W'(VALUE_WIDTH - 1);
      neg  <= word[VALUE_WIDTH-1] && (mode == RADIX_DEC);
    end else if (shift_en) begin
      mag  <= mag << 1;
      iter <= iter - 1'b1;
    end
  end

  assign carry[0] = mag[VALUE_WIDTH-1];

  // Row of digit cells; cell 0 holds the least significant digit.
  // Hex mode loads the nibbles straight in, decimal mode starts from zero.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    assign load_digits[i] = (mode == RADIX_HEX) ? padded[4*i +: 4] : 4'd0;

    ita_cell u_cell (
      .clk        (clk),
      .load       (accept),
      .shift      (shift_en),
      .load_digit (load_digits[i]),
      .carry_in   (carry[i]),
      .carry_out  (carry[i+1]),
      .digit      (digits[i])
    );
  end

  // Count of significant digits; zero still shows one digit.
  always_comb begin
    ndig = CNT_W'(1);
    for (int i = 1; i < NUM_CELLS; i++) begin
      if (digits[i] != '0) begin
        ndig = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    result.neg    = neg;
    result.ndig   = ndig;
    result.digits = digits;
  end

  // The converter takes no word while it is shifting.
  assert property (@(posedge clk) disable iff (rst)
    (state == CONV_RUN) |-> !in_ready)
    else $error("word accepted during conversion");

  // The digit row is wide enough that no carry ever leaves the top cell.
  assert property (@(posedge clk) disable iff (rst)
    (state == CONV_RUN) |-> !carry[NUM_CELLS])
    else $error("decimal overflow out of top digit cell");

  // A decimal word always goes through the shift phase.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == RADIX_DEC)) |=> (state == CONV_RUN))
    else $error("decimal word skipped conversion");

endmodule

`default_nettype wire

// ===== hdl/ita_emit.sv =====
`default_nettype none

module ita_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             hand_valid,
  output logic                             hand_ready,
  input  ita_pkg::ita_result_t             result,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ita_pkg::CHAR_WIDTH-1:0]   character,
  output logic                             last
);
  import ita_pkg::*;

  logic                   busy;
  logic                   neg_pend;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_m1;
  digit_t [NUM_CELLS-1:0] digs;
  logic                   out_xfer;
  logic                   load;

  assign out_valid  = busy;
  assign out_xfer   = out_valid && out_ready;
  assign last       = busy && !neg_pend && (cnt == CNT_W'(1));
  // The next result loads as the final character of this one transfers.
  assign hand_ready = !busy || (out_xfer && last);
  assign load       = hand_valid && hand_ready;

  // Characters leave from the top significant digit down.
  assign cnt_m1    = cnt - 1'b1;
  assign character = neg_pend ? CH_MINUS : digit_char(digs[cnt_m1[IDX_W-1:0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      cnt      <= '0;
    end else if (load) begin
      busy     <= 1'b1;
      neg_pend <= result.neg;
      cnt      <= result.ndig;
    end else if (out_xfer) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else if (last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digs <= result.digits;
    end
  end

  // A text in progress always has at least one digit left.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("emitter busy with no digits left");

  // A new result replaces the current one only on its final transfer.
  assert property (@(posedge clk) disable iff (rst)
    (load && busy) |-> (out_xfer && last))
    else $error("result overwritten before its text finished");

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_format.sv =====
// Formats one integer word per input transfer as ASCII text, one character
// per output transfer, most significant first, with no leading zeros and
// last set on the final character. radix_mode 0 gives signed decimal with a
// leading '-' for negative values; radix_mode 1 gives unsigned lower-case
// hex. Decimal conversion runs the magnitude through a row of BCD digit
// cells one bit per cycle, and the converter takes no new word while it
// shifts; a hex word loads its nibbles straight into the cells. The
// characters of one word leave at one per cycle while out_ready is high,
// from a separate output stage while the next word converts, so a hex
// stream runs at the character rate (up to 8 per word).
// radix_mode must only change while the block is idle.
`default_nettype none

module integer_to_ascii_format (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ita_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ita_pkg::CHAR_WIDTH-1:0]         character,
  output logic                                   last
);
  import ita_pkg::*;

  logic        radix_mode;
  logic        hand_valid;
  logic        hand_ready;
  ita_result_t hand_result;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= RADIX_DEC;
    end else if (cfg_wr_en) begin
      radix_mode <= cfg_wr_data;
    end
  end

  ita_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .mode       (radix_mode),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .result     (hand_result)
  );

  ita_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .result     (hand_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .last       (last)
  );

endmodule

`default_nettype wire
